@@ design/compressed_rtf_lz_decompressor_macros.svh @@
// ----------------------------------------------------------------------------
// Compressed RTF decompressor assertion macros
// Assertion wrappers that compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef COMPRESSED_RTF_LZ_DECOMPRESSOR_MACROS_SVH
`define COMPRESSED_RTF_LZ_DECOMPRESSOR_MACROS_SVH
`ifndef SYNTH
`define RTFLZ_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("rtflz assertion failed");
`define RTFLZ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("rtflz assertion failed");
`else
`define RTFLZ_ASSERT(label, clk, rstn, prop)
`define RTFLZ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ design/rtflz_pkg.sv @@
// ----------------------------------------------------------------------------
// Compressed RTF decompressor package
// Payload types, dictionary port types, codes and the RTF preset text.
// ----------------------------------------------------------------------------
package rtflz_pkg;

    localparam int DICT_DEPTH    = 4096;
    localparam int DICT_AW       = 12;
    localparam int PRESET_LENGTH = 207;

    localparam logic [31:0] MAGIC_COMPRESSED   = 32'h75465a4c;
    localparam logic [31:0] MAGIC_UNCOMPRESSED = 32'h414c454d;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic [1:0] status;
        logic       out_last;
    } out_item_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_HDR   = 2'd1,
        STATUS_OVERFLOW  = 2'd2,
        STATUS_TRUNCATED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MODE_HEADER = 2'd0,
        MODE_RAW    = 2'd1,
        MODE_LZ     = 2'd2,
        MODE_DONE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIT,
        ST_RD,
        ST_WR,
        ST_FIN,
        ST_CLOSE
    } state_t;

    typedef struct packed {
        logic               en;
        logic [DICT_AW-1:0] addr;
        logic [7:0]         data;
    } dict_wr_t;

    typedef struct packed {
        logic               en;
        logic [DICT_AW-1:0] addr;
        logic [DICT_AW:0]   fill;
    } dict_rd_t;

    localparam logic [PRESET_LENGTH*8-1:0] RTF_PRESET = {
        "{\\rtf1\\ansi\\mac\\deff0\\deftab720{\\fonttbl;}",
        "{\\f0\\fnil \\froman \\fswiss \\fmodern \\fscrip",
        "t \\fdecor MS Sans SerifSymbolArialTimes Ne",
        "w RomanCourier{\\colortbl\\red0\\green0\\blue0",
        "\015\012\\par \\pard\\plain\\f0\\fs20\\b\\i\\u\\tab",
        "\\tx"
    };

    // Power-up content of one dictionary entry: preset text, then zeros.
    function automatic logic [7:0] preset_byte(input logic [DICT_AW-1:0] addr);
        logic [7:0] b;
        b = 8'd0;
        if (addr < DICT_AW'(PRESET_LENGTH)) begin
            b = RTF_PRESET[(DICT_AW'(PRESET_LENGTH - 1) - addr) * 8 +: 8];
        end
        return b;
    endfunction

endpackage

@@ design/rtflz_dict_ram.sv @@
// ----------------------------------------------------------------------------
// Dictionary ring memory
// 4096 x 8 synchronous RAM; entries not yet written in this stream read as
// the preset, decided by the fill count.
// ----------------------------------------------------------------------------
module rtflz_dict_ram (
    input  logic               aclk,
    input  rtflz_pkg::dict_wr_t wr,
    input  rtflz_pkg::dict_rd_t rd,
    output logic [7:0]         rd_data
);
    import rtflz_pkg::*;

    logic [7:0]         mem [DICT_DEPTH];
    logic [7:0]         mem_q_reg;
    logic [7:0]         pre_q_reg;
    logic               written_q_reg;
    logic [DICT_AW-1:0] span;
    logic               written;

    // Writes start at the end of the preset, so an entry holds stream data
    // when its distance past that point is below the fill count.
    assign span    = rd.addr - DICT_AW'(PRESET_LENGTH);
    assign written = rd.fill[DICT_AW] || (span < rd.fill[DICT_AW-1:0]);

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            mem_q_reg     <= mem[rd.addr];
            pre_q_reg     <= preset_byte(rd.addr);
            written_q_reg <= written;
        end
    end

    assign rd_data = written_q_reg ? mem_q_reg : pre_q_reg;

endmodule

@@ design/compressed_rtf_lz_decompressor.sv @@
// ----------------------------------------------------------------------------
// Compressed RTF decompressor
// Header check, pass-through and LZ decode over a 4096-byte ring dictionary.
// ----------------------------------------------------------------------------
// One stream byte is taken at a time. A header or control byte goes from ST_IDLE
// to ST_CLOSE, a literal or pass-through byte through ST_LIT, and a reference
// through ST_RD and ST_WR for each expanded byte, since every dictionary byte is
// read from the ring RAM and written back before the next read. The final result
// of a stream is sent from ST_FIN (on overflow, ST_LIT/ST_WR). No clearing pass is
// needed after reset or between streams: a fill count marks ring entries that hold stream data.
module compressed_rtf_lz_decompressor (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [31:0]          cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rtflz_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rtflz_pkg::out_item_t m_data
);
    import rtflz_pkg::*;
    `include "compressed_rtf_lz_decompressor_macros.svh"

    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [4:0]         hdr_idx_reg, hdr_idx_next;
    logic [31:0]        size_reg, size_next;
    logic [31:0]        raw_size_reg, raw_size_next;
    logic [31:0]        magic_reg, magic_next;
    logic [31:0]        stream_len_reg;
    logic [7:0]         ctrl_reg, ctrl_next;
    logic [3:0]         elem_reg, elem_next;
    logic [7:0]         phigh_reg, phigh_next;
    logic               rhalf_reg, rhalf_next;
    logic [32:0]        produced_reg, produced_next;
    logic [DICT_AW-1:0] wp_reg, wp_next;
    logic [DICT_AW-1:0] rptr_reg, rptr_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [7:0]         byte_reg, byte_next;
    logic               last_reg, last_next;
    logic               raw_lit_reg, raw_lit_next;
    logic               fin_pend_reg, fin_pend_next;
    status_t            fin_status_reg, fin_status_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    dict_wr_t           dwr;
    dict_rd_t           drd;
    logic [7:0]         dict_q;
    logic               out_free;
    logic               over;
    logic               hdr_good;
    logic [DICT_AW-1:0] ref_off;
    logic [3:0]         elem_inc;

    rtflz_dict_ram u_dict (
        .aclk    (aclk),
        .wr      (dwr),
        .rd      (drd),
        .rd_data (dict_q)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign over     = produced_reg > ({1'b0, raw_size_reg} + 33'd20);
    assign hdr_good = (size_reg == stream_len_reg - 32'd4) &&
                      ((magic_reg == MAGIC_COMPRESSED) ||
                       (magic_reg == MAGIC_UNCOMPRESSED));
    assign ref_off  = {phigh_reg, s_data.in_byte[7:4]};
    assign elem_inc = elem_reg + 4'd1;

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        hdr_idx_next    = hdr_idx_reg;
        size_next       = size_reg;
        raw_size_next   = raw_size_reg;
        magic_next      = magic_reg;
        ctrl_next       = ctrl_reg;
        elem_next       = elem_reg;
        phigh_next      = phigh_reg;
        rhalf_next      = rhalf_reg;
        produced_next   = produced_reg;
        wp_next         = wp_reg;
        rptr_next       = rptr_reg;
        cnt_next        = cnt_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        raw_lit_next    = raw_lit_reg;
        fin_pend_next   = fin_pend_reg;
        fin_status_next = fin_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        dwr             = '{en: 1'b0, addr: wp_reg, data: 8'd0};
        drd             = '{en: 1'b0, addr: rptr_reg,
                            fill: produced_reg[32:DICT_AW] != '0
                                  ? (DICT_AW+1)'(DICT_DEPTH)
                                  : produced_reg[DICT_AW:0]};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    byte_next     = s_data.in_byte;
                    last_next     = s_data.in_last;
                    fin_pend_next = 1'b0;
                    state_next    = ST_CLOSE;
                    unique case (mode_reg)
                        MODE_HEADER: begin
                            hdr_idx_next = hdr_idx_reg + 5'd1;
                            unique case (hdr_idx_reg[3:2])
                                2'd0: size_next[hdr_idx_reg[1:0]*8 +: 8] = s_data.in_byte;
                                2'd1: raw_size_next[hdr_idx_reg[1:0]*8 +: 8] =
                                          s_data.in_byte;
                                2'd2: magic_next[hdr_idx_reg[1:0]*8 +: 8] = s_data.in_byte;
                                default: ;
                            endcase
                            if (hdr_idx_reg == 5'd15) begin
                                if (!hdr_good) begin
                                    fin_status_next = STATUS_BAD_HDR;
                                    state_next      = ST_FIN;
                                end else begin
                                    mode_next = (magic_reg == MAGIC_COMPRESSED)
                                                ? MODE_LZ : MODE_RAW;
                                    if (s_data.in_last) begin
                                        fin_status_next = STATUS_OK;
                                        state_next      = ST_FIN;
                                    end
                                end
                            end else if (s_data.in_last) begin
                                fin_status_next = STATUS_BAD_HDR;
                                state_next      = ST_FIN;
                            end
                        end
                        MODE_RAW: begin
                            raw_lit_next    = 1'b1;
                            fin_pend_next   = s_data.in_last;
                            fin_status_next = STATUS_OK;
                            state_next      = ST_LIT;
                        end
                        MODE_LZ: begin
                            priority if (elem_reg[3]) begin
                                // A control byte, alone at the end, closes cleanly.
                                ctrl_next = s_data.in_byte;
                                elem_next = 4'd0;
                                if (s_data.in_last) begin
                                    fin_status_next = STATUS_OK;
                                    state_next      = ST_FIN;
                                end
                            end else if (ctrl_reg[elem_reg[2:0]]) begin
                                if (!rhalf_reg) begin
                                    phigh_next = s_data.in_byte;
                                    rhalf_next = 1'b1;
                                    if (s_data.in_last) begin
                                        fin_status_next = STATUS_TRUNCATED;
                                        state_next      = ST_FIN;
                                    end
                                end else begin
                                    rhalf_next = 1'b0;
                                    elem_next  = elem_inc;
                                    if (ref_off == wp_reg) begin
                                        // End-of-stream marker.
                                        fin_status_next = STATUS_OK;
                                        state_next      = ST_FIN;
                                    end else begin
                                        rptr_next       = ref_off;
                                        cnt_next        = {1'b0, s_data.in_byte[3:0]} + 5'd2;
                                        fin_pend_next   = s_data.in_last;
                                        fin_status_next = elem_inc[3] ? STATUS_OK
                                                                      : STATUS_TRUNCATED;
                                        state_next      = ST_RD;
                                    end
                                end
                            end else begin
                                elem_next       = elem_inc;
                                raw_lit_next    = 1'b0;
                                fin_pend_next   = s_data.in_last;
                                fin_status_next = elem_inc[3] ? STATUS_OK
                                                              : STATUS_TRUNCATED;
                                state_next      = ST_LIT;
                            end
                        end
                        MODE_DONE: ;
                    endcase
                end
            end
            ST_LIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (!raw_lit_reg && over) begin
                        m_data_next = '{out_byte: 8'd0, out_valid: 1'b0,
                                        status: STATUS_OVERFLOW, out_last: 1'b1};
                        mode_next   = MODE_DONE;
                        state_next  = ST_CLOSE;
                    end else begin
                        m_data_next = '{out_byte: byte_reg, out_valid: 1'b1,
                                        status: STATUS_OK, out_last: 1'b0};
                        if (!raw_lit_reg) begin
                            dwr           = '{en: 1'b1, addr: wp_reg, data: byte_reg};
                            wp_next       = wp_reg + DICT_AW'(1);
                            produced_next = produced_reg + 33'd1;
                        end
                        state_next = fin_pend_reg ? ST_FIN : ST_CLOSE;
                    end
                end
            end
            ST_RD: begin
                drd.en     = 1'b1;
                state_next = ST_WR;
            end
            ST_WR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (over) begin
                        m_data_next = '{out_byte: 8'd0, out_valid: 1'b0,
                                        status: STATUS_OVERFLOW, out_last: 1'b1};
                        mode_next   = MODE_DONE;
                        state_next  = ST_CLOSE;
                    end else begin
                        m_data_next   = '{out_byte: dict_q, out_valid: 1'b1,
                                          status: STATUS_OK, out_last: 1'b0};
                        dwr           = '{en: 1'b1, addr: wp_reg, data: dict_q};
                        wp_next       = wp_reg + DICT_AW'(1);
                        produced_next = produced_reg + 33'd1;
                        rptr_next     = rptr_reg + DICT_AW'(1);
                        cnt_next      = cnt_reg - 5'd1;
                        if (cnt_reg == 5'd1) begin
                            state_next = fin_pend_reg ? ST_FIN : ST_CLOSE;
                        end else begin
                            state_next = ST_RD;
                        end
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_byte: 8'd0, out_valid: 1'b0,
                                     status: fin_status_reg, out_last: 1'b1};
                    mode_next    = MODE_DONE;
                    state_next   = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                // A stream's last byte rearms all but the stream length register.
                if (last_reg) begin
                    mode_next     = MODE_HEADER;
                    hdr_idx_next  = 5'd0;
                    size_next     = 32'd0;
                    raw_size_next = 32'd0;
                    magic_next    = 32'd0;
                    ctrl_next     = 8'd0;
                    elem_next     = 4'd8;
                    phigh_next    = 8'd0;
                    rhalf_next    = 1'b0;
                    produced_next = 33'd0;
                    wp_next       = DICT_AW'(PRESET_LENGTH);
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_HEADER;
            hdr_idx_reg    <= 5'd0;
            size_reg       <= 32'd0;
            raw_size_reg   <= 32'd0;
            magic_reg      <= 32'd0;
            stream_len_reg <= 32'd16;
            ctrl_reg       <= 8'd0;
            elem_reg       <= 4'd8;
            phigh_reg      <= 8'd0;
            rhalf_reg      <= 1'b0;
            produced_reg   <= 33'd0;
            wp_reg         <= DICT_AW'(PRESET_LENGTH);
            m_valid_reg    <= 1'b0;
            last_reg       <= 1'b0;
            fin_pend_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            hdr_idx_reg  <= hdr_idx_next;
            size_reg     <= size_next;
            raw_size_reg <= raw_size_next;
            magic_reg    <= magic_next;
            ctrl_reg     <= ctrl_next;
            elem_reg     <= elem_next;
            phigh_reg    <= phigh_next;
            rhalf_reg    <= rhalf_next;
            produced_reg <= produced_next;
            wp_reg       <= wp_next;
            m_valid_reg  <= m_valid_next;
            last_reg     <= last_next;
            fin_pend_reg <= fin_pend_next;
            if (cfg_wr_en) begin
                stream_len_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rptr_reg       <= rptr_next;
        cnt_reg        <= cnt_next;
        byte_reg       <= byte_next;
        raw_lit_reg    <= raw_lit_next;
        fin_status_reg <= fin_status_next;
        m_data_reg     <= m_data_next;
    end

    `RTFLZ_ASSERT(a_wr_loads_out, aclk, aresetn, dwr.en |=> m_valid_reg && m_data_reg.out_valid)
    `RTFLZ_ASSERT(a_wp_steps, aclk, aresetn, dwr.en |=> wp_reg == $past(wp_reg) + DICT_AW'(1))
    `RTFLZ_ASSERT(a_final_no_byte, aclk, aresetn, (m_valid_reg && m_data_reg.out_last) |-> !m_data_reg.out_valid)
    `RTFLZ_ASSERT_ALWAYS(a_rd_then_wr, aclk, drd.en |=> state_reg == ST_WR)

endmodule
